@@ rtl/gb5_pkg.sv @@
// Shared constants, types and helpers for the 5x5 RGB blur.
package gb5_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MIN_DIM    = 5;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int DIM_W    = 12;
  localparam int CENTER_W = 11;
  localparam int CHAN_W   = 8;
  localparam int LINES    = 4;
  localparam int WIN      = 5;
  localparam int WIN_EDGE = WIN - 1;
  localparam int HALF_WIN = WIN / 2;

  localparam int WIDE_COL_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
  localparam int WIDE_ROW_W = (ROW_W + 1 > DIM_W) ? ROW_W + 1 : DIM_W;

  localparam int VSUM_W = CHAN_W + 4;
  localparam int HSUM_W = VSUM_W + 4;

  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 48;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  typedef logic [3*CHAN_W-1:0] pixel_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                valid;
    logic [CENTER_W-1:0] center_column;
    logic [CENTER_W-1:0] center_row;
    logic                last;
  } ctrl_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center_row;
    logic [CENTER_W-1:0] center_column;
    logic [CHAN_W-1:0]   blue;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   red;
  } result_t;

  typedef struct packed {
    logic    last;
    result_t data;
  } out_item_t;

  function automatic logic [DIM_W-1:0] bound_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(MIN_DIM)) r = DIM_W'(MIN_DIM);
    else if (v > hi)         r = hi;
    else                     r = v;
    return r;
  endfunction

endpackage

@@ rtl/gb5_window.sv @@
// Position counters, four line buffers and the 5x5 pixel window.
module gb5_window import gb5_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  input  logic             accept,
  input  pixel_t           pix,
  input  logic             sof,
  output logic             produce,
  output pixel_t           window [WIN][WIN],
  output ctrl_t            ctrl
);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  logic [COL_W-1:0]      col_base, col_cur;
  logic [ROW_W-1:0]      row_base, row_cur;
  logic [WIDE_ROW_W-1:0] row_step;
  logic [WIDE_COL_W-1:0] col_inc;
  logic [WIDE_ROW_W-1:0] row_inc;
  logic                  last_cur;

  // item in the line-buffer stage
  logic             s1_valid;
  pixel_t           s1_pix;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_prod;
  logic             s1_last;
  logic             s1_fwd;

  pixel_t rd_data   [LINES];
  pixel_t last_wr   [LINES];
  pixel_t col_data  [WIN];

  logic                ctrl_valid;
  logic [CENTER_W-1:0] ctrl_col;
  logic [CENTER_W-1:0] ctrl_row;
  logic                ctrl_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_eff  = bound_dim(image_width, DIM_W'(MAX_WIDTH));
  assign height_eff = bound_dim(image_height, DIM_W'(MAX_HEIGHT));

  // position of the incoming pixel, after frame start and size-change wraps
  always_comb begin
    col_base = sof ? '0 : column_count;
    row_base = sof ? '0 : row_count;
    if (WIDE_COL_W'(col_base) >= WIDE_COL_W'(width_eff)) begin
      col_cur  = '0;
      row_step = WIDE_ROW_W'(row_base) + WIDE_ROW_W'(1);
    end else begin
      col_cur  = col_base;
      row_step = WIDE_ROW_W'(row_base);
    end
    row_cur  = (row_step >= WIDE_ROW_W'(height_eff)) ? '0 : row_step[ROW_W-1:0];
    col_inc  = WIDE_COL_W'(col_cur) + WIDE_COL_W'(1);
    row_inc  = WIDE_ROW_W'(row_cur) + WIDE_ROW_W'(1);
    produce  = (col_cur >= COL_W'(WIN_EDGE)) && (row_cur >= ROW_W'(WIN_EDGE));
    last_cur = (col_inc == WIDE_COL_W'(width_eff)) && (row_inc == WIDE_ROW_W'(height_eff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_inc >= WIDE_COL_W'(width_eff)) begin
        column_count <= '0;
        row_count    <= (row_inc >= WIDE_ROW_W'(height_eff)) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        column_count <= col_inc[COL_W-1:0];
        row_count    <= row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= pix;
      s1_col  <= col_cur;
      s1_row  <= row_cur;
      s1_prod <= produce;
      s1_last <= last_cur;
      // the item now writing this column lands after our read: take its data
      s1_fwd  <= s1_valid && (s1_col == col_cur);
    end
  end

  always_comb begin
    for (int r = 0; r < LINES; r++) begin
      col_data[r] = s1_fwd ? last_wr[r] : rd_data[r];
    end
    col_data[WIN-1] = s1_pix;
  end

  for (genvar g = 0; g < LINES; g++) begin : g_line
    pixel_t mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (s1_valid) mem[s1_col] <= col_data[g+1];
      if (accept)   rd_data[g]  <= mem[col_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int r = 0; r < LINES; r++) begin
        last_wr[r] <= col_data[r+1];
      end
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN - 1; c++) begin
          window[r][c] <= window[r][c+1];
        end
        window[r][WIN-1] <= col_data[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ctrl_valid <= 1'b0;
    else     ctrl_valid <= s1_valid && s1_prod;
  end

  always_ff @(posedge clk) begin
    ctrl_col  <= CENTER_W'(s1_col - COL_W'(HALF_WIN));
    ctrl_row  <= CENTER_W'(s1_row - ROW_W'(HALF_WIN));
    ctrl_last <= s1_last;
  end

  assign ctrl = '{valid: ctrl_valid, center_column: ctrl_col,
                  center_row: ctrl_row, last: ctrl_last};

endmodule

@@ rtl/gb5_lane.sv @@
// One color channel: binomial 5x5 weighted sum, column pass then row pass.
module gb5_lane import gb5_pkg::*; (
  input  logic              clk,
  input  logic [CHAN_W-1:0] px [WIN][WIN],
  output logic [CHAN_W-1:0] blurred
);

  logic [VSUM_W-1:0] vsum [WIN];
  logic [HSUM_W-1:0] hsum;

  // weights 1 4 6 4 1 down each column
  always_ff @(posedge clk) begin
    for (int c = 0; c < WIN; c++) begin
      vsum[c] <= VSUM_W'(px[0][c])
               + (VSUM_W'(px[1][c]) << 2)
               + (VSUM_W'(px[2][c]) << 2) + (VSUM_W'(px[2][c]) << 1)
               + (VSUM_W'(px[3][c]) << 2)
               + VSUM_W'(px[4][c]);
    end
  end

  // same weights across the columns; divide by 256 by dropping the low byte
  always_comb begin
    hsum = HSUM_W'(vsum[0])
         + (HSUM_W'(vsum[1]) << 2)
         + (HSUM_W'(vsum[2]) << 2) + (HSUM_W'(vsum[2]) << 1)
         + (HSUM_W'(vsum[3]) << 2)
         + HSUM_W'(vsum[4]);
  end

  always_ff @(posedge clk) begin
    blurred <= hsum[HSUM_W-1 -: CHAN_W];
  end

endmodule

@@ rtl/gb5_out_fifo.sv @@
// Output queue with credit count so input is held back before it can overflow.
module gb5_out_fifo import gb5_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      reserve,
  input  logic      push,
  input  out_item_t push_item,
  input  logic      pop_ready,
  output logic      room,
  output logic      out_valid,
  output out_item_t head
);

  out_item_t             store [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [OUT_CNT_W-1:0]  fill, fill_next;
  logic [OUT_CNT_W-1:0]  credits, credits_next;
  logic                  pop;

  assign pop       = out_valid && pop_ready;
  assign out_valid = (fill != '0);
  assign head      = store[rd_ptr];
  assign room      = (credits < OUT_CNT_W'(OUT_DEPTH));

  always_comb begin
    fill_next    = fill + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    credits_next = credits + OUT_CNT_W'(reserve) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      credits <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      fill    <= fill_next;
      credits <= credits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_item;
  end

  // every queued or in-flight item holds a credit
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (fill < OUT_CNT_W'(OUT_DEPTH) || pop))
    else $error("push into full output queue");

  a_credit_covers_fill: assert property (@(posedge clk) disable iff (rst)
    credits >= fill)
    else $error("queued items exceed credits");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= OUT_CNT_W'(OUT_DEPTH))
    else $error("credit count beyond queue depth");

endmodule

@@ rtl/gaussian_blur_5x5_rgb.sv @@
// Streaming 5x5 binomial blur on RGB pixels in raster order. The block takes
// one pixel per clock and keeps taking them while results wait downstream,
// as long as its 8-item output queue has room; each pixel's column is read
// from the four line buffers at the edge that takes it and written back in
// the next cycle; the result for the window center two rows up and two
// columns left goes through the window, column-sum and blurred registers
// to the output queue. Centers within two pixels of an edge give no item.
// Frame size comes from the width (index 0) and height (index 1) registers,
// bounded to 5..2048, and must be changed only while idle (not enforced).
module gaussian_blur_5x5_rgb import gb5_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [DIM_W-1:0]       cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // red_in, green_in, blue_in
  input  logic                   s_axis_tuser,   // start_of_frame
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // red_out, green_out, blue_out,
                                                 // center_column, center_row, pad
  output logic                   m_axis_tlast    // last_of_frame
);

  logic        accept;
  logic        produce;
  pixel_t      pix;
  pixel_t      window [WIN][WIN];
  ctrl_t       ctrl2, ctrl3, ctrl4;
  logic [CHAN_W-1:0] lane_px  [3][WIN][WIN];
  logic [CHAN_W-1:0] lane_out [3];
  out_item_t   push_item;
  out_item_t   head;
  logic        room;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign pix    = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  gb5_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .pix       (pix),
    .sof       (s_axis_tuser),
    .produce   (produce),
    .window    (window),
    .ctrl      (ctrl2)
  );

  // lane 0 blue, 1 green, 2 red
  for (genvar k = 0; k < 3; k++) begin : g_lane
    always_comb begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN; c++) begin
          lane_px[k][r][c] = window[r][c][k*CHAN_W +: CHAN_W];
        end
      end
    end

    gb5_lane u_lane (
      .clk     (clk),
      .px      (lane_px[k]),
      .blurred (lane_out[k])
    );
  end

  always_ff @(posedge clk) begin
    ctrl3.center_column <= ctrl2.center_column;
    ctrl3.center_row    <= ctrl2.center_row;
    ctrl3.last          <= ctrl2.last;
    ctrl4.center_column <= ctrl3.center_column;
    ctrl4.center_row    <= ctrl3.center_row;
    ctrl4.last          <= ctrl3.last;
    if (rst) begin
      ctrl3.valid <= 1'b0;
      ctrl4.valid <= 1'b0;
    end else begin
      ctrl3.valid <= ctrl2.valid;
      ctrl4.valid <= ctrl3.valid;
    end
  end

  // merge the three channels with the position of the center
  assign push_item = '{last: ctrl4.last,
                       data: '{center_row:    ctrl4.center_row,
                               center_column: ctrl4.center_column,
                               blue:          lane_out[0],
                               green:         lane_out[1],
                               red:           lane_out[2]}};

  gb5_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .reserve   (accept && produce),
    .push      (ctrl4.valid),
    .push_item (push_item),
    .pop_ready (m_axis_tready),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .head      (head)
  );

  assign s_axis_tready = room;
  assign m_axis_tdata  = TDATA_OUT_W'(head.data);
  assign m_axis_tlast  = head.last;

endmodule

@@ tb/gaussian_blur_5x5_rgb_test.sv @@
// Self-checking testbench for the streaming 5x5 RGB binomial blur.
module gaussian_blur_5x5_rgb_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gb5_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              sof;
  } px_item_t;

  typedef struct {
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [CENTER_W-1:0] ccol;
    logic [CENTER_W-1:0] crow;
    logic                frame_end;
  } blur_result_t;

  typedef enum { ROW_WRITE, ROW_PIXEL } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    reg_index_t       index;
    logic [DIM_W-1:0] value;
    px_item_t         px;
    bit               typed;
    blur_result_t     want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  reg_index_t             cfg_index = REG_WIDTH;
  logic [DIM_W-1:0]       cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   m_tlast;

  gaussian_blur_5x5_rgb uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // predictor state
  bit [3*CHAN_W-1:0] line_mem [LINES][MAX_WIDTH];
  bit [3*CHAN_W-1:0] win [WIN][WIN];
  int                col_pos = 0;
  int                row_pos = 0;
  int                max_col_written = -1;
  logic [DIM_W-1:0]  width_reg = WIDTH_RESET;
  logic [DIM_W-1:0]  height_reg = HEIGHT_RESET;

  blur_result_t pending_blurs[$];
  int           errors = 0;
  int           items_sent = 0;
  int           results_checked = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           hold_request = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  task automatic note_failure(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic stim_row_t blank_row();
    stim_row_t b;
    b.kind = ROW_PIXEL;
    b.index = REG_WIDTH;
    b.value = '0;
    b.px = '{default: '0};
    b.typed = 1'b0;
    b.want = '{default: '0};
    return b;
  endfunction

  function automatic int bounded(input int v, input int hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int tap(input int i);
    case (i)
      0, 4: return 1;
      1, 3: return 4;
      default: return 6;
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] blur_chan(input int shift);
    int sum;
    sum = 0;
    for (int r = 0; r < WIN; r++)
      for (int c = 0; c < WIN; c++)
        sum += tap(r) * tap(c) * int'((win[r][c] >> shift) & 24'hFF);
    return CHAN_W'(sum >> 8);
  endfunction

  // Advances the predictor by one pixel; hit says whether a center is due.
  task automatic predict_blur(input px_item_t px, output bit hit, output blur_result_t res);
    int w, h, c, r;
    bit [3*CHAN_W-1:0] colv [WIN];
    w = bounded(width_reg, MAX_WIDTH);
    h = bounded(height_reg, MAX_HEIGHT);
    if (px.sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    // size may have shrunk since the last pixel
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    for (int i = 0; i < LINES; i++) colv[i] = line_mem[i][c];
    colv[LINES] = {px.red, px.green, px.blue};
    for (int i = 0; i < LINES; i++) line_mem[i][c] = colv[i+1];
    if (c > max_col_written) max_col_written = c;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN - 1; j++) win[i][j] = win[i][j+1];
      win[i][WIN-1] = colv[i];
    end
    hit = (c >= WIN_EDGE && r >= WIN_EDGE);
    res.red = blur_chan(16);
    res.green = blur_chan(8);
    res.blue = blur_chan(0);
    res.ccol = CENTER_W'(c - HALF_WIN);
    res.crow = CENTER_W'(r - HALF_WIN);
    res.frame_end = (c == w - 1 && r == h - 1);
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic write_dim(input reg_index_t idx, input logic [DIM_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_WIDTH) width_reg = v;
    else height_reg = v;
    @(posedge clk);
  endtask

  task automatic send_pixel(input px_item_t px, input bit typed, input blur_result_t want);
    bit fire, hit;
    blur_result_t res;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {px.blue, px.green, px.red};
    s_tuser <= px.sof;
    fire = 0;
    // sample mid-cycle; the item is taken at the following edge
    while (!fire) begin
      @(negedge clk);
      fire = s_tready;
      @(posedge clk);
    end
    predict_blur(px, hit, res);
    if (hit) pending_blurs.push_back(typed ? want : res);
    items_sent++;
  endtask

  // Block is idle once every result is back and the pipeline has flushed.
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    while (pending_blurs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CHAN_W-1:0] rand_level();
    int k;
    k = $urandom_range(9);
    if (k == 0) return '0;
    if (k == 1) return '1;
    return CHAN_W'($urandom_range(255));
  endfunction

  task automatic set_mode(input int mode);
    case (mode)
      0: begin send_idle_pct = 26; recv_idle_pct = 82; end
      1: begin send_idle_pct = 82; recv_idle_pct = 26; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // Result side: random stalls plus an occasional long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(negedge clk) begin : check_results
    blur_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.red = m_tdata[7:0];
      got.green = m_tdata[15:8];
      got.blue = m_tdata[23:16];
      got.ccol = m_tdata[34:24];
      got.crow = m_tdata[45:35];
      got.frame_end = m_tlast;
      results_checked++;
      if (pending_blurs.size() == 0) begin
        note_failure($sformatf("unexpected result at col %0d row %0d", got.ccol, got.crow));
      end else begin
        want = pending_blurs.pop_front();
        if (got.red !== want.red)
          note_failure($sformatf("red at (%0d,%0d): got %0d, want %0d",
                                 want.ccol, want.crow, got.red, want.red));
        if (got.green !== want.green)
          note_failure($sformatf("green at (%0d,%0d): got %0d, want %0d",
                                 want.ccol, want.crow, got.green, want.green));
        if (got.blue !== want.blue)
          note_failure($sformatf("blue at (%0d,%0d): got %0d, want %0d",
                                 want.ccol, want.crow, got.blue, want.blue));
        if (got.ccol !== want.ccol)
          note_failure($sformatf("center column: got %0d, want %0d", got.ccol, want.ccol));
        if (got.crow !== want.crow)
          note_failure($sformatf("center row: got %0d, want %0d", got.crow, want.crow));
        if (got.frame_end !== want.frame_end)
          note_failure($sformatf("frame end at (%0d,%0d): got %0d, want %0d",
                                 want.ccol, want.crow, got.frame_end, want.frame_end));
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_blurs.size());
        $display("gaussian_blur_5x5_rgb_test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t    rows[$];
    stim_row_t    row;
    px_item_t     px;
    blur_result_t none;
    int           phase, n, random_items, mode, last_mode, w, h;
    bit           fresh;
    logic [DIM_W-1:0] w_raw, h_raw;

    none = '{default: '0};
    // directed: width 3 and height 0 both act as 5, then one 5x5 frame with
    // red saturated, green zero and a single blue spike in the middle
    row = blank_row();
    row.kind = ROW_WRITE;
    row.index = REG_WIDTH;
    row.value = DIM_W'(3);
    rows.push_back(row);
    row.index = REG_HEIGHT;
    row.value = '0;
    rows.push_back(row);
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        row = blank_row();
        row.kind = ROW_PIXEL;
        row.px.red = 8'd255;
        row.px.green = 8'd0;
        row.px.blue = (r == 2 && c == 2) ? 8'd255 : 8'd0;
        row.px.sof = (r == 0 && c == 0);
        if (r == 4 && c == 4) begin
          row.typed = 1;
          row.want = '{red: 8'd255, green: 8'd0, blue: 8'd35,
                       ccol: 11'd2, crow: 11'd2, frame_end: 1'b1};
        end
        rows.push_back(row);
      end
    end

    set_mode(0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) write_dim(rows[i].index, rows[i].value);
      else send_pixel(rows[i].px, rows[i].typed, rows[i].want);
    end
    finish_phase();

    // random phases: mostly whole small frames, some continuing mid-frame
    // after a size change
    phase = 0;
    random_items = 0;
    last_mode = -1;
    while (random_items < RANDOM_ITEMS) begin
      mode = (random_items < RANDOM_ITEMS / 3) ? 0 :
             (random_items < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
      set_mode(mode);
      if (mode != last_mode && mode != 1) hold_request = 1;
      last_mode = mode;
      fresh = (phase == 0) || ($urandom_range(9) < 7);
      n = $urandom_range(99);
      if (n < 8) w_raw = DIM_W'($urandom_range(MIN_DIM - 1));
      else if (n < 85) w_raw = DIM_W'($urandom_range(12, 5));
      else w_raw = DIM_W'($urandom_range(48, 13));
      h_raw = ($urandom_range(99) < 8) ? DIM_W'($urandom_range(MIN_DIM - 1))
                                       : DIM_W'($urandom_range(10, 5));
      // a frame in progress must not reach columns no pixel has filled yet
      if (!fresh && bounded(w_raw, MAX_WIDTH) > max_col_written + 1)
        w_raw = DIM_W'(max_col_written + 1);
      if (fresh || $urandom_range(1)) write_dim(REG_WIDTH, w_raw);
      if (fresh || $urandom_range(1)) write_dim(REG_HEIGHT, h_raw);
      n = $urandom_range(200, 60);
      for (int k = 0; k < n; k++) begin
        px.red = rand_level();
        px.green = rand_level();
        px.blue = rand_level();
        px.sof = (k == 0 && fresh) || ($urandom_range(199) == 0);
        send_pixel(px, 0, none);
      end
      random_items += n;
      finish_phase();
      phase++;
    end

    // height written above its bound acts as 2048: a narrow frame runs on
    // past the small heights with no early wrap
    set_mode(2);
    write_dim(REG_WIDTH, DIM_W'(MIN_DIM));
    write_dim(REG_HEIGHT, '1);
    w = bounded(width_reg, MAX_WIDTH);
    h = 16;
    for (int k = 0; k < w * h; k++) begin
      px.red = rand_level();
      px.green = rand_level();
      px.blue = rand_level();
      px.sof = (k == 0);
      send_pixel(px, 0, none);
    end
    finish_phase();

    while (pending_blurs.size() != 0) begin
      note_failure($sformatf("result for col %0d row %0d never came",
                             pending_blurs[0].ccol, pending_blurs[0].crow));
      void'(pending_blurs.pop_front());
    end
    $display("Sent %0d pixels in %0d small-frame phases plus a tall frame past the height bound,",
             items_sent, phase);
    $display("checked %0d blurred pixels under three stall mixes and long output hold-offs.",
             results_checked);
    if (errors == 0) begin
      $display("gaussian_blur_5x5_rgb_test passed");
    end else begin
      $display("gaussian_blur_5x5_rgb_test failed");
    end
    $finish;
  end

endmodule
